[rtl/core/vptd_pkg.sv]
// Shared constants and types of the postings tail decoder.
package vptd_pkg;

    // Size of a full postings block; a tail holds fewer entries than this.
    localparam int BLOCK_ENTRIES = 128;
    // Default depth of the queue between the front and back halves.
    localparam int QUEUE_DEPTH   = 2;

    localparam int ENTRY_W    = 7;
    localparam int DOC_W      = 32;
    localparam int BASE_W     = 31;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Entry counter saturates here, so last is raised at most once per tail.
    localparam logic [ENTRY_W-1:0] ENTRY_CAP =
        ((BLOCK_ENTRIES - 1) > 127) ? ENTRY_W'(127) : ENTRY_W'(BLOCK_ENTRIES - 1);

    // Most groups of 7 bits taken for one integer.
    localparam logic [2:0] MAX_GROUPS = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DOC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd2;

    typedef struct packed {
        logic               freq_present;
        logic [BASE_W-1:0]  base_doc;
        logic [ENTRY_W-1:0] entry_count;
    } t_cfg;

    // One decoded posting, handed from front to back.
    typedef struct packed {
        logic              restart;
        logic [BASE_W-1:0] base;
        logic [DOC_W-1:0]  delta;
        logic [DOC_W-1:0]  freq;
    } t_cmd;

    // Queue status seen by both halves.
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

[rtl/core/vptd_front.sv]
// Front half: accepts tail bytes, assembles integers and classifies them.
module vptd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vptd_pkg::t_cfg              i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [vptd_pkg::BYTE_W-1:0] i_tail_byte,
    input  logic                        i_first_of_tail,
    input  vptd_pkg::t_qstat            i_qstat,
    output logic                        o_push,
    output vptd_pkg::t_cmd              o_cmd
);
    import vptd_pkg::*;

    logic [DOC_W-1:0]  r_acc, n_acc;
    logic [2:0]        r_sp, n_sp;
    logic              r_aw, n_aw;
    logic [BASE_W-1:0] r_pd, n_pd;
    logic              r_rst_pend, n_rst_pend;
    logic [BASE_W-1:0] r_base, n_base;

    logic              accept;
    logic [DOC_W-1:0]  acc0, acc1, part;
    logic [2:0]        sp0, sp1;
    logic              aw0;
    logic [BASE_W-1:0] pd0;
    logic              push;
    logic [DOC_W-1:0]  delta, freq;

    assign o_in_stall = i_qstat.full;
    assign accept     = i_in_valid && !i_qstat.full;

    always_comb begin
        acc0 = i_first_of_tail ? '0 : r_acc;
        sp0  = i_first_of_tail ? '0 : r_sp;
        aw0  = i_first_of_tail ? 1'b0 : r_aw;
        pd0  = i_first_of_tail ? '0 : r_pd;

        case (sp0)
            3'd0:    part = {25'b0, i_tail_byte[6:0]};
            3'd1:    part = {18'b0, i_tail_byte[6:0], 7'b0};
            3'd2:    part = {11'b0, i_tail_byte[6:0], 14'b0};
            3'd3:    part = {4'b0, i_tail_byte[6:0], 21'b0};
            3'd4:    part = {i_tail_byte[3:0], 28'b0};
            default: part = '0;
        endcase

        // groups past the fifth add nothing
        if (sp0 < MAX_GROUPS) begin
            acc1 = acc0 | part;
            sp1  = sp0 + 3'd1;
        end else begin
            acc1 = acc0;
            sp1  = sp0;
        end

        n_acc = r_acc;
        n_sp  = r_sp;
        n_aw  = r_aw;
        n_pd  = r_pd;
        push  = 1'b0;
        delta = '0;
        freq  = '0;

        if (accept) begin
            if (i_tail_byte[7]) begin
                n_acc = acc1;
                n_sp  = sp1;
                n_aw  = aw0;
                n_pd  = pd0;
            end else begin
                n_acc = '0;
                n_sp  = '0;
                n_aw  = aw0;
                n_pd  = pd0;
                if (aw0) begin
                    push  = 1'b1;
                    delta = {1'b0, pd0};
                    freq  = acc1;
                    n_aw  = 1'b0;
                    n_pd  = '0;
                end else if (i_cfg.freq_present) begin
                    if (acc1[0]) begin
                        push  = 1'b1;
                        delta = {1'b0, acc1[DOC_W-1:1]};
                        freq  = DOC_W'(1);
                    end else begin
                        n_pd = acc1[DOC_W-1:1];
                        n_aw = 1'b1;
                    end
                end else begin
                    push  = 1'b1;
                    delta = acc1;
                    freq  = DOC_W'(1);
                end
            end
        end

        // Hold a restart until the next entry carries it to the back half.
        n_rst_pend = r_rst_pend;
        n_base     = r_base;
        if (accept && i_first_of_tail) begin
            n_base = i_cfg.base_doc;
        end
        if (push) begin
            n_rst_pend = 1'b0;
        end else if (accept && i_first_of_tail) begin
            n_rst_pend = 1'b1;
        end
    end

    assign o_push        = push;
    assign o_cmd.restart = r_rst_pend || (accept && i_first_of_tail);
    assign o_cmd.base    = (accept && i_first_of_tail) ? i_cfg.base_doc : r_base;
    assign o_cmd.delta   = delta;
    assign o_cmd.freq    = freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_sp       <= '0;
            r_aw       <= 1'b0;
            r_pd       <= '0;
            r_rst_pend <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_sp       <= n_sp;
            r_aw       <= n_aw;
            r_pd       <= n_pd;
            r_rst_pend <= n_rst_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
    end

endmodule

[rtl/core/vptd_queue.sv]
// Short FIFO of decoded postings between the front and back halves.
module vptd_queue #(
    parameter int DEPTH = vptd_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  vptd_pkg::t_cmd              i_cmd,
    input  logic                        i_pop,
    output vptd_pkg::t_cmd              o_cmd,
    output vptd_pkg::t_qstat            o_qstat,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    import vptd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd         = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_count       = r_count;

endmodule

[rtl/core/vptd_back.sv]
// Back half: accumulates doc ids, counts entries and holds the result register.
module vptd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [vptd_pkg::ENTRY_W-1:0] i_entry_count,
    input  vptd_pkg::t_qstat             i_qstat,
    input  vptd_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [vptd_pkg::DOC_W-1:0]   o_doc_id,
    output logic [vptd_pkg::DOC_W-1:0]   o_freq,
    output logic                         o_last
);
    import vptd_pkg::*;

    logic [DOC_W-1:0]   r_running, n_running;
    logic [ENTRY_W-1:0] r_done, n_done;
    logic               r_valid, n_valid;
    logic [DOC_W-1:0]   r_doc, r_freq;
    logic               r_last, n_last;

    logic               pop;
    logic [DOC_W-1:0]   run_base;
    logic [ENTRY_W-1:0] done_base;

    assign pop = !i_qstat.empty && (!r_valid || !i_out_stall);

    always_comb begin
        run_base  = i_cmd.restart ? {1'b0, i_cmd.base} : r_running;
        done_base = i_cmd.restart ? '0 : r_done;
        n_running = r_running;
        n_done    = r_done;
        n_last    = 1'b0;
        if (pop) begin
            n_running = run_base + i_cmd.delta;
            n_done    = done_base;
            if (done_base < ENTRY_CAP) begin
                n_last = (done_base + ENTRY_W'(1) == i_entry_count);
                n_done = done_base + ENTRY_W'(1);
            end
        end
        if (pop) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_done    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_running <= n_running;
            r_done    <= n_done;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_doc  <= n_running;
            r_freq <= i_cmd.freq;
            r_last <= n_last;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_valid;
    assign o_doc_id    = r_doc;
    assign o_freq      = r_freq;
    assign o_last      = r_last;

endmodule

[rtl/core/vint_postings_tail_decoder_core.sv]
// A byte that completes an entry is written into the queue, then popped into the result register.
// Throughput: one tail byte per cycle while the queue is not full, set by the single-byte integer assembler in front.
// The back half retires one entry per cycle while the output is not stalled; a short queue absorbs output stalls.
// Reset (synchronous, active low) clears decode state and the queue, and loads
// freq_present = 1, base_doc = 0, entry_count = 1.
module vint_postings_tail_decoder_core #(
    parameter int QUEUE_DEPTH = vptd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tail byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [vptd_pkg::BYTE_W-1:0]     i_tail_byte,
    input  logic                            i_first_of_tail,
    // decoded posting channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [vptd_pkg::DOC_W-1:0]      o_doc_id,
    output logic [vptd_pkg::DOC_W-1:0]      o_freq,
    output logic                            o_last,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vptd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vptd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vptd_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg, n_cfg;
    t_cmd             front_cmd, queue_cmd;
    t_qstat           qstat;
    logic             push, pop;
    logic [CNT_W-1:0] q_count;

    // Register writes are always taken; the caller only writes while idle.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FREQ_PRESENT: n_cfg.freq_present = i_cfg_data[0];
                CFG_BASE_DOC:     n_cfg.base_doc     = i_cfg_data[BASE_W-1:0];
                CFG_ENTRY_COUNT:  n_cfg.entry_count  = i_cfg_data[ENTRY_W-1:0];
                default:          n_cfg = r_cfg;   // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_present <= 1'b1;
            r_cfg.base_doc     <= '0;
            r_cfg.entry_count  <= ENTRY_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: assemble integers a byte at a time, pair doc codes with freqs,
    // and carry the start-of-tail restart along with the next entry.
    vptd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_tail_byte     (i_tail_byte),
        .i_first_of_tail (i_first_of_tail),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Queue: decouple byte intake from result delivery.
    vptd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_qstat (qstat),
        .o_count (q_count)
    );

    // Back: advance the running doc id, count entries, drive the result register.
    vptd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_cfg.entry_count),
        .i_qstat       (qstat),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_doc_id      (o_doc_id),
        .o_freq        (o_freq),
        .o_last        (o_last)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("entry pushed into full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("entry popped from empty queue");

    // Occupancy rises by one on a push without a pop.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (q_count == $past(q_count) + CNT_W'(1)))
        else $error("queue count out of step with pushes");

    // A result is loaded only when the register is free or being taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !pop)
        else $error("stalled result overwritten");

endmodule
